[src/x86eu_pkg.sv]
package x86eu_pkg;

  // data memory size in bytes, a power of two
  localparam int unsigned MEM_BYTES  = 65536;
  localparam int unsigned MEM_AW     = $clog2(MEM_BYTES);
  localparam int unsigned BANK_AW    = MEM_AW - 1;
  localparam int unsigned BANK_DEPTH = MEM_BYTES / 2;
  // wide enough for base + index + signed displacement without overflow
  localparam int unsigned SUM_W      = ((MEM_AW > 18) ? MEM_AW : 18) + 1;

  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_AW     = $clog2(NUM_REGS);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [15:0] MSB_MASK = 16'h8000;

  typedef enum logic [3:0] {
    OP_MOV = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_CMP = 4'd3,
    OP_JE  = 4'd4,
    OP_JNE = 4'd5,
    OP_JS  = 4'd6,
    OP_JNS = 4'd7,
    OP_JL  = 4'd8,
    OP_JNL = 4'd9,
    OP_JLE = 4'd10,
    OP_JG  = 4'd11,
    OP_NOP = 4'd12
  } req_type_e;

  typedef enum logic [1:0] {
    DST_REG = 2'd0,
    DST_MEM = 2'd1,
    DST_JMP = 2'd2
  } dst_kind_e;

  typedef enum logic [1:0] {
    SRC_REG = 2'd0,
    SRC_IMM = 2'd1,
    SRC_MEM = 2'd2
  } src_kind_e;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_MOV  = 2'd1,
    CLS_ALU  = 2'd2,
    CLS_JMP  = 2'd3
  } op_class_e;

  typedef enum logic [2:0] {
    COND_Z   = 3'd0,
    COND_NZ  = 3'd1,
    COND_S   = 3'd2,
    COND_NS  = 3'd3,
    COND_ZS  = 3'd4,
    COND_NZS = 3'd5
  } cond_e;

  typedef struct packed {
    op_class_e          cls;
    logic               is_add;
    logic               wr_dst;
    cond_e              cond;
    logic               wide;
    dst_kind_e          dst_kind;
    src_kind_e          src_kind;
    logic [REG_AW-1:0]  dst_reg;
    logic [REG_AW-1:0]  src_reg;
    logic [15:0]        imm;
    logic               base_en;
    logic [REG_AW-1:0]  base_reg;
    logic               index_en;
    logic [REG_AW-1:0]  index_reg;
    logic [15:0]        disp;
    logic [7:0]         jump_offset;
    logic [2:0]         instr_length;
  } instr_t;

  typedef struct packed {
    logic   valid;
    instr_t item;
  } queue_head_t;

endpackage

[src/x86eu_ram.sv]
module x86eu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/x86eu_front.sv]
module x86eu_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [x86eu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic [x86eu_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output x86eu_pkg::queue_head_t              head_o,
  input  logic                                pop_i
);

  x86eu_pkg::instr_t                      dec;
  x86eu_pkg::instr_t                      queue_q [x86eu_pkg::QUEUE_DEPTH];
  logic [x86eu_pkg::QPTR_W-1:0]           wr_ptr_q, wr_ptr_d;
  logic [x86eu_pkg::QPTR_W-1:0]           rd_ptr_q, rd_ptr_d;
  logic [x86eu_pkg::QCNT_W-1:0]           cnt_q, cnt_d;
  logic                                   push;
  logic                                   pop;

  // classify the operation while the fields are unpacked
  always_comb begin
    dec              = '0;
    dec.wide         = s_axis_tdata[0];
    dec.dst_kind     = x86eu_pkg::dst_kind_e'(s_axis_tdata[2:1]);
    dec.src_kind     = x86eu_pkg::src_kind_e'(s_axis_tdata[4:3]);
    dec.dst_reg      = s_axis_tdata[7:5];
    dec.src_reg      = s_axis_tdata[10:8];
    dec.imm          = s_axis_tdata[26:11];
    dec.base_en      = !s_axis_tdata[30];
    dec.base_reg     = s_axis_tdata[29:27];
    dec.index_en     = !s_axis_tdata[34];
    dec.index_reg    = s_axis_tdata[33:31];
    dec.disp         = s_axis_tdata[50:35];
    dec.jump_offset  = s_axis_tdata[58:51];
    dec.instr_length = s_axis_tdata[61:59];
    dec.cls          = x86eu_pkg::CLS_NONE;
    dec.cond         = x86eu_pkg::COND_Z;
    case (x86eu_pkg::req_type_e'(s_axis_tuser)) 
      x86eu_pkg::OP_MOV: begin
        dec.cls    = x86eu_pkg::CLS_MOV;
        dec.wr_dst = 1'b1;
      end
      x86eu_pkg::OP_ADD: begin
        dec.cls    = x86eu_pkg::CLS_ALU;
        dec.is_add = 1'b1;
        dec.wr_dst = 1'b1;
      end
      x86eu_pkg::OP_SUB: begin
        dec.cls    = x86eu_pkg::CLS_ALU;
        dec.wr_dst = 1'b1;
      end
      x86eu_pkg::OP_CMP: dec.cls = x86eu_pkg::CLS_ALU;
      x86eu_pkg::OP_JE: begin
        dec.cls  = x86eu_pkg::CLS_JMP;
        dec.cond = x86eu_pkg::COND_Z;
      end
      x86eu_pkg::OP_JNE: begin
        dec.cls  = x86eu_pkg::CLS_JMP;
        dec.cond = x86eu_pkg::COND_NZ;
      end
      x86eu_pkg::OP_JS, x86eu_pkg::OP_JL: begin
        dec.cls  = x86eu_pkg::CLS_JMP;
        dec.cond = x86eu_pkg::COND_S;
      end
      x86eu_pkg::OP_JNS, x86eu_pkg::OP_JNL: begin
        dec.cls  = x86eu_pkg::CLS_JMP;
        dec.cond = x86eu_pkg::COND_NS;
      end
      x86eu_pkg::OP_JLE: begin
        dec.cls  = x86eu_pkg::CLS_JMP;
        dec.cond = x86eu_pkg::COND_ZS;
      end
      x86eu_pkg::OP_JG: begin
        dec.cls  = x86eu_pkg::CLS_JMP;
        dec.cond = x86eu_pkg::COND_NZS;
      end
      default: dec.cls = x86eu_pkg::CLS_NONE;
    endcase
  end

  assign s_axis_tready = (cnt_q != x86eu_pkg::QCNT_W'(x86eu_pkg::QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == x86eu_pkg::QPTR_W'(x86eu_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + x86eu_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == x86eu_pkg::QPTR_W'(x86eu_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + x86eu_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + x86eu_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - x86eu_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = queue_q[rd_ptr_q];

endmodule

[src/x86eu_back.sv]
module x86eu_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  x86eu_pkg::queue_head_t              head_i,
  output logic                                pop_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [x86eu_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  // stage b: address from base and index, memory read issued
  // stage c: operands ready, result computed and written back
  logic                                b_vld_q, c_vld_q;
  x86eu_pkg::instr_t                   b_item_q, c_item_q;
  logic [x86eu_pkg::MEM_AW-1:0]        c_addr_q;
  logic                                a_go;
  logic                                c_done;

  logic [15:0]                         ip_q, ip_d;
  logic                                zf_q, zf_d, sf_q, sf_d;
  logic [x86eu_pkg::NUM_REGS-1:0]      rf_vld_q;

  logic                                out_vld_q;
  logic [15:0]                         out_ip_q, out_res_q;
  logic                                out_zf_q, out_sf_q;

  // register file: two copies, one read port each
  logic                                rf_re;
  logic [x86eu_pkg::REG_AW-1:0]        rf_a_raddr, rf_b_raddr;
  logic [15:0]                         rf_a_rdata, rf_b_rdata;
  logic                                rf_we;
  logic [x86eu_pkg::REG_AW-1:0]        rf_waddr;
  logic                                vld_a_q, vld_b_q, fw_a_q, fw_b_q;
  logic [15:0]                         fw_data_q;
  logic [15:0]                         rf_a_val, rf_b_val;

  // data memory split into even and odd byte banks
  logic [x86eu_pkg::MEM_AW-1:0]        b_addr;
  logic [x86eu_pkg::SUM_W-1:0]         addr_sum;
  logic [15:0]                         base_val, index_val;
  logic [x86eu_pkg::BANK_AW-1:0]       b_row, b_row_inc, c_row, c_row_inc;
  logic [x86eu_pkg::BANK_AW-1:0]       ev_raddr, ev_waddr;
  logic [7:0]                          ev_rdata, od_rdata, ev_wdata, od_wdata;
  logic                                ev_we, od_we, mem_we;

  logic [15:0]                         load_val, dst_val, src_val, alu_res, result;
  logic                                take, jump_taken;
  logic [7:0]                          lo_byte, hi_byte;

  assign a_go   = head_i.valid && !b_vld_q && (!c_vld_q || c_done);
  assign pop_o  = a_go;
  assign c_done = c_vld_q && (!out_vld_q || m_axis_tready);

  // register file reads: base and index in the issue cycle, operands in stage b
  assign rf_re      = a_go || b_vld_q;
  assign rf_a_raddr = a_go ? head_i.item.base_reg : b_item_q.dst_reg;
  assign rf_b_raddr = a_go ? head_i.item.index_reg : b_item_q.src_reg;
  assign rf_we      = c_done && c_item_q.wr_dst && (c_item_q.dst_kind == x86eu_pkg::DST_REG);
  assign rf_waddr   = c_item_q.dst_reg;

  x86eu_ram #(.Width(16), .Depth(x86eu_pkg::NUM_REGS)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (result),
    .re_i    (rf_re),
    .raddr_i (rf_a_raddr),
    .rdata_o (rf_a_rdata)
  );

  x86eu_ram #(.Width(16), .Depth(x86eu_pkg::NUM_REGS)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (result),
    .re_i    (rf_re),
    .raddr_i (rf_b_raddr),
    .rdata_o (rf_b_rdata)
  );

  // a write-back in the issue cycle is forwarded, never-written registers read as zero
  always_ff @(posedge clk_i) begin
    if (a_go) begin
      fw_a_q    <= rf_we && (rf_waddr == head_i.item.base_reg);
      fw_b_q    <= rf_we && (rf_waddr == head_i.item.index_reg);
      fw_data_q <= result;
      vld_a_q   <= rf_vld_q[head_i.item.base_reg];
      vld_b_q   <= rf_vld_q[head_i.item.index_reg];
    end else if (b_vld_q) begin
      fw_a_q    <= 1'b0;
      fw_b_q    <= 1'b0;
      vld_a_q   <= rf_vld_q[b_item_q.dst_reg];
      vld_b_q   <= rf_vld_q[b_item_q.src_reg];
    end
  end

  assign rf_a_val = fw_a_q ? fw_data_q : (vld_a_q ? rf_a_rdata : 16'h0000);
  assign rf_b_val = fw_b_q ? fw_data_q : (vld_b_q ? rf_b_rdata : 16'h0000);

  // stage b: effective address
  assign base_val  = b_item_q.base_en ? rf_a_val : 16'h0000;
  assign index_val = b_item_q.index_en ? rf_b_val : 16'h0000;
  assign addr_sum  = x86eu_pkg::SUM_W'(base_val) + x86eu_pkg::SUM_W'(index_val)
                   + {{(x86eu_pkg::SUM_W - 16){b_item_q.disp[15]}}, b_item_q.disp};
  assign b_addr    = addr_sum[x86eu_pkg::MEM_AW-1:0];
  assign b_row     = b_addr[x86eu_pkg::MEM_AW-1:1];
  assign b_row_inc = b_row + x86eu_pkg::BANK_AW'(1);
  assign ev_raddr  = b_addr[0] ? b_row_inc : b_row;

  // stage c: memory write, odd start puts the high byte in the next even row
  assign c_row     = c_addr_q[x86eu_pkg::MEM_AW-1:1];
  assign c_row_inc = c_row + x86eu_pkg::BANK_AW'(1);
  assign mem_we    = c_done && c_item_q.wr_dst && (c_item_q.dst_kind == x86eu_pkg::DST_MEM);
  assign ev_we     = mem_we && (!c_addr_q[0] || c_item_q.wide);
  assign od_we     = mem_we && (c_addr_q[0] || c_item_q.wide);
  assign ev_waddr  = c_addr_q[0] ? c_row_inc : c_row;
  assign ev_wdata  = c_addr_q[0] ? result[15:8] : result[7:0];
  assign od_wdata  = c_addr_q[0] ? result[7:0] : result[15:8];

  x86eu_ram #(.Width(8), .Depth(x86eu_pkg::BANK_DEPTH)) u_mem_even (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (ev_wdata),
    .re_i    (b_vld_q),
    .raddr_i (ev_raddr),
    .rdata_o (ev_rdata)
  );

  x86eu_ram #(.Width(8), .Depth(x86eu_pkg::BANK_DEPTH)) u_mem_odd (
    .clk_i   (clk_i),
    .we_i    (od_we),
    .waddr_i (c_row),
    .wdata_i (od_wdata),
    .re_i    (b_vld_q),
    .raddr_i (b_row),
    .rdata_o (od_rdata)
  );

  // stage c: execute
  assign lo_byte  = c_addr_q[0] ? od_rdata : ev_rdata;
  assign hi_byte  = c_addr_q[0] ? ev_rdata : od_rdata;
  assign load_val = c_item_q.wide ? {hi_byte, lo_byte} : {8'h00, lo_byte};

  always_comb begin
    case (c_item_q.dst_kind)
      x86eu_pkg::DST_REG: dst_val = rf_a_val;
      x86eu_pkg::DST_MEM: dst_val = load_val;
      default:            dst_val = 16'h0000;
    endcase
    case (c_item_q.src_kind)
      x86eu_pkg::SRC_REG: src_val = rf_b_val;
      x86eu_pkg::SRC_IMM: src_val = c_item_q.imm;
      x86eu_pkg::SRC_MEM: src_val = load_val;
      default:            src_val = 16'h0000;
    endcase
    case (c_item_q.cond)
      x86eu_pkg::COND_Z:   take = zf_q;
      x86eu_pkg::COND_NZ:  take = !zf_q;
      x86eu_pkg::COND_S:   take = sf_q;
      x86eu_pkg::COND_NS:  take = !sf_q;
      x86eu_pkg::COND_ZS:  take = zf_q || sf_q;
      x86eu_pkg::COND_NZS: take = !zf_q && !sf_q;
      default:             take = 1'b0;
    endcase
  end

  assign alu_res = c_item_q.is_add ? (dst_val + src_val) : (dst_val - src_val);

  always_comb begin
    case (c_item_q.cls)
      x86eu_pkg::CLS_MOV: result = src_val;
      x86eu_pkg::CLS_ALU: result = alu_res;
      default:            result = 16'h0000;
    endcase
  end

  assign jump_taken = (c_item_q.cls == x86eu_pkg::CLS_JMP) && take
                      && (c_item_q.dst_kind == x86eu_pkg::DST_JMP);

  always_comb begin
    ip_d = ip_q + {13'b0, c_item_q.instr_length};
    if (jump_taken) begin
      ip_d = ip_d + {{8{c_item_q.jump_offset[7]}}, c_item_q.jump_offset};
    end
    zf_d = zf_q;
    sf_d = sf_q;
    if (c_item_q.cls == x86eu_pkg::CLS_ALU) begin
      zf_d = (alu_res == 16'h0000);
      sf_d = |(alu_res & x86eu_pkg::MSB_MASK);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      ip_q      <= '0;
      zf_q      <= 1'b0;
      sf_q      <= 1'b0;
      rf_vld_q  <= '0;
    end else begin
      b_vld_q <= a_go;
      if (b_vld_q) begin
        c_vld_q <= 1'b1;
      end else if (c_done) begin
        c_vld_q <= 1'b0;
      end
      if (c_done) begin
        out_vld_q <= 1'b1;
        ip_q      <= ip_d;
        zf_q      <= zf_d;
        sf_q      <= sf_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_item_q <= head_i.item;
    end
    if (b_vld_q) begin
      c_item_q <= b_item_q;
      c_addr_q <= b_addr;
    end
    if (c_done) begin
      out_ip_q  <= ip_d;
      out_zf_q  <= zf_d;
      out_sf_q  <= sf_d;
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_res_q, out_sf_q, out_zf_q, out_ip_q};

  // b and c are never occupied together, so memory writes never meet a read in flight
  a_bc_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(b_vld_q && c_vld_q))
    else $error("stage b and stage c both occupied");

  a_b_to_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |=> c_vld_q)
    else $error("stage b did not move into stage c");

  a_c_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_vld_q && !c_done) |=> (c_vld_q && $stable(c_addr_q)))
    else $error("stalled stage c lost its item");

  a_write_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_we || od_we || rf_we) |-> c_done)
    else $error("state written outside of completion");

  a_issue_needs_c_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_go |-> (!c_vld_q || c_done))
    else $error("issue while stage c still holds an item");

endmodule

[src/x86_16bit_execute_unit.sv]
// a transfer accepted into an empty unit passes the queue, stage b and stage c before its
// result shows on m_axis; no instruction issues while stage b holds one, set by the back end's
//   two-step sequence (register read for the address, then byte bank read before write-back)
// the two-entry queue keeps taking transfers while the back end works or the output stalls
// reset: registers, instruction pointer, flags and queue clear at once; data memory keeps
//   no reset value and gets no clearing pass
module x86_16bit_execute_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // wide[0] dst_kind[2:1] src_kind[4:3] dst_reg[7:5] src_reg[10:8] imm_value[26:11]
  // mem_base[30:27] mem_index[34:31] mem_disp[50:35] jump_offset[58:51]
  // instr_length[61:59], zero fill above
  input  logic [x86eu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type[3:0]
  input  logic [x86eu_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // next_ip[15:0] zero_flag[16] sign_flag[17] result_value[33:18], zero fill above
  output logic [x86eu_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  x86eu_pkg::queue_head_t head;
  logic                   pop;

  x86eu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .head_o        (head),
    .pop_i         (pop)
  );

  x86eu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[test/tb.sv]
module tb;
  import x86eu_pkg::*;

  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          RAND_PER_PHASE = 560;
  localparam int          N_DIR          = 26;
  // byte pool for memory traffic, straddles the top of memory so word accesses wrap
  localparam int          POOL_BASE      = MEM_BYTES - 32;
  localparam int          POOL_SPAN      = 64;

  localparam logic [2:0]  R_AX = 3'd0;
  localparam logic [2:0]  R_CX = 3'd1;
  localparam logic [2:0]  R_DX = 3'd2;
  localparam logic [2:0]  R_BX = 3'd3;
  localparam logic [2:0]  R_SI = 3'd6;
  localparam logic [3:0]  BASE_NONE   = 4'd8;
  localparam logic [3:0]  BASE_BAD    = 4'd15;
  // request codes above OP_NOP behave as no-ops
  localparam logic [3:0]  REQ_LAST    = 4'd15;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [3:0]  req;
    logic        wide;
    logic [1:0]  dst_kind;
    logic [1:0]  src_kind;
    logic [2:0]  dst_reg;
    logic [2:0]  src_reg;
    logic [15:0] imm;
    logic [3:0]  base_reg;
    logic [3:0]  idx_reg;
    logic [15:0] disp;
    logic [7:0]  joff;
    logic [2:0]  len;
  } instr_fields_t;

  typedef struct packed {
    logic [15:0] next_ip;
    logic        zf;
    logic        sf;
    logic [15:0] value;
  } exec_result_t;

  typedef struct packed {
    instr_fields_t ins;
    logic          typed;
    exec_result_t  want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  x86_16bit_execute_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // architectural state as the unit should hold it
  logic [15:0]  reg_q [NUM_REGS];
  logic [15:0]  ip_q;
  logic         zf_q;
  logic         sf_q;
  logic [7:0]   mem_img [int];
  int           written_q [$];

  exec_result_t queued_results_q [$];  // instruction offered, transfer not yet taken
  exec_result_t due_results_q [$];     // instruction taken, result still owed
  exec_result_t exp_res;
  int           src_idle_pct;
  int           dst_idle_pct;
  int           fail_cnt;
  int           n_sent;
  int           n_checked;
  int           cyc_cnt;
  stim_row_t    dir_tab [N_DIR];

  function automatic int eff_addr(instr_fields_t f);
    int sum;
    sum = 0;
    if (f.base_reg < NUM_REGS) sum += int'(reg_q[f.base_reg[2:0]]);
    if (f.idx_reg < NUM_REGS) sum += int'(reg_q[f.idx_reg[2:0]]);
    sum += int'($signed(f.disp));
    sum = sum % int'(MEM_BYTES);
    if (sum < 0) sum += int'(MEM_BYTES);
    return sum;
  endfunction

  function automatic logic [15:0] load_mem(int a, logic wide);
    logic [15:0] v;
    int          a_hi;
    v    = '0;
    a_hi = (a + 1) % MEM_BYTES;
    if (mem_img.exists(a)) v[7:0] = mem_img[a];
    if (wide && mem_img.exists(a_hi)) v[15:8] = mem_img[a_hi];
    return v;
  endfunction

  function automatic void store_byte(int a, logic [7:0] b);
    if (!mem_img.exists(a)) written_q.push_back(a);
    mem_img[a] = b;
  endfunction

  function automatic logic [15:0] src_val(instr_fields_t f, int a);
    case (f.src_kind)
      SRC_REG: return reg_q[f.src_reg];
      SRC_IMM: return f.imm;
      SRC_MEM: return load_mem(a, f.wide);
      default: return '0;
    endcase
  endfunction

  function automatic logic [15:0] dst_val(instr_fields_t f, int a);
    case (f.dst_kind)
      DST_REG: return reg_q[f.dst_reg];
      DST_MEM: return load_mem(a, f.wide);
      default: return '0;
    endcase
  endfunction

  function automatic void write_dst(instr_fields_t f, int a, logic [15:0] v);
    case (f.dst_kind)
      DST_REG: reg_q[f.dst_reg] = v;
      DST_MEM: begin
        store_byte(a, v[7:0]);
        if (f.wide) store_byte((a + 1) % MEM_BYTES, v[15:8]);
      end
      default: ;
    endcase
  endfunction

  function automatic exec_result_t execute_instr(instr_fields_t f);
    exec_result_t r;
    logic [15:0]  lhs;
    logic [15:0]  rhs;
    logic [15:0]  nxt;
    logic         take;
    int           a;
    r    = '0;
    take = 1'b0;
    a    = eff_addr(f);
    nxt  = ip_q + 16'(f.len);
    case (f.req)
      OP_MOV: begin
        r.value = src_val(f, a);
        write_dst(f, a, r.value);
      end
      OP_ADD, OP_SUB, OP_CMP: begin
        lhs     = dst_val(f, a);
        rhs     = src_val(f, a);
        r.value = (f.req == OP_ADD) ? lhs + rhs : lhs - rhs;
        if (f.req != OP_CMP) write_dst(f, a, r.value);
        zf_q = (r.value == '0);
        sf_q = ((r.value & MSB_MASK) != '0);
      end
      OP_JE:  take = zf_q;
      OP_JNE: take = !zf_q;
      OP_JS:  take = sf_q;
      OP_JNS: take = !sf_q;
      // jl/jnl only look at the sign flag
      OP_JL:  take = sf_q;
      OP_JNL: take = !sf_q;
      OP_JLE: take = zf_q || sf_q;
      OP_JG:  take = !zf_q && !sf_q;
      default: ;
    endcase
    if (take && f.dst_kind == DST_JMP) nxt = nxt + {{8{f.joff[7]}}, f.joff};
    ip_q      = nxt;
    r.next_ip = nxt;
    r.zf      = zf_q;
    r.sf      = sf_q;
    return r;
  endfunction

  function automatic instr_fields_t random_instr();
    instr_fields_t f;
    int            pick;
    int            tgt;
    logic          rd;
    pick = $urandom_range(99);
    if (pick < 25) f.req = OP_MOV;
    else if (pick < 65) f.req = 4'($urandom_range(OP_ADD, OP_CMP));
    else if (pick < 92) f.req = 4'($urandom_range(OP_JE, OP_JG));
    else f.req = 4'($urandom_range(OP_NOP, REQ_LAST));
    f.wide = 1'($urandom);
    pick = $urandom_range(99);
    if (f.req inside {[OP_JE:OP_JG]}) begin
      f.dst_kind = (pick < 85) ? DST_JMP : 2'($urandom);
    end else begin
      f.dst_kind = (pick < 50) ? DST_REG : (pick < 85) ? DST_MEM : 2'($urandom);
    end
    pick = $urandom_range(99);
    f.src_kind = (pick < 35) ? SRC_REG : (pick < 65) ? SRC_IMM :
                 (pick < 92) ? SRC_MEM : 2'($urandom);
    f.dst_reg = 3'($urandom);
    f.src_reg = 3'($urandom);
    case ($urandom_range(9))
      0: f.imm = '0;
      1: f.imm = '1;
      2: f.imm = MSB_MASK;
      3: f.imm = ~MSB_MASK;
      4: f.imm = reg_q[f.dst_reg];  // drives sub/cmp to zero
      default: f.imm = 16'($urandom);
    endcase
    f.base_reg = ($urandom_range(99) < 85) ? 4'($urandom_range(NUM_REGS)) : 4'($urandom);
    f.idx_reg  = ($urandom_range(99) < 85) ? 4'($urandom_range(NUM_REGS)) : 4'($urandom);
    f.disp     = 16'($urandom);
    f.joff     = 8'($urandom);
    f.len      = ($urandom_range(99) < 95) ? 3'($urandom_range(1, 6)) : 3'($urandom);

    // memory is only ever read where it has been written
    tgt = -1;
    rd  = (f.req == OP_MOV && f.src_kind == SRC_MEM) ||
          (f.req inside {OP_ADD, OP_SUB, OP_CMP} &&
           (f.src_kind == SRC_MEM || f.dst_kind == DST_MEM));
    if (rd && written_q.size() == 0) begin
      f.src_kind = SRC_IMM;
      if (f.req != OP_MOV && f.dst_kind == DST_MEM) f.dst_kind = DST_REG;
    end else if (rd) begin
      tgt = written_q[$urandom_range(written_q.size() - 1)];
      if (!mem_img.exists((tgt + 1) % MEM_BYTES)) f.wide = 1'b0;
    end
    if (!rd && f.req == OP_MOV && f.dst_kind == DST_MEM && $urandom_range(99) < 80)
      tgt = (POOL_BASE + $urandom_range(POOL_SPAN - 1)) % MEM_BYTES;
    if (tgt >= 0) begin
      f.disp = '0;
      f.disp = 16'(tgt - eff_addr(f));
    end
    return f;
  endfunction

  task automatic send_instr(input instr_fields_t f, input logic typed,
                            input exec_result_t want);
    exec_result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    pred = execute_instr(f);
    queued_results_q.push_back(typed ? want : pred);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({f.len, f.joff, f.disp, f.idx_reg, f.base_reg, f.imm,
                                 f.src_reg, f.dst_reg, f.src_kind, f.dst_kind, f.wide});
    s_axis_tuser  <= f.req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (queued_results_q.size() != 0 || due_results_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
      fail_cnt++;
    end
  endfunction

  // input transfer: the instruction's result becomes due
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      due_results_q.push_back(queued_results_q.pop_front());
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results_q.size() == 0) begin
        $error("result transfer with no instruction outstanding: %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_res = due_results_q.pop_front();
        check_field("next_ip", exp_res.next_ip, m_axis_tdata[15:0]);
        check_field("zero_flag", 16'(exp_res.zf), 16'(m_axis_tdata[16]));
        check_field("sign_flag", 16'(exp_res.sf), 16'(m_axis_tdata[17]));
        check_field("result_value", exp_res.value, m_axis_tdata[33:18]);
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cyc_cnt,
               queued_results_q.size() + due_results_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    src_idle_pct  = 0;
    dst_idle_pct  = 0;
    fail_cnt      = 0;
    n_sent        = 0;
    n_checked     = 0;
    cyc_cnt       = 0;
    foreach (reg_q[i]) reg_q[i] = '0;
    ip_q = '0;
    zf_q = 1'b0;
    sf_q = 1'b0;

    // fields: req wide dst_kind src_kind dst_reg src_reg imm base idx disp joff len
    dir_tab = '{
      '{'{OP_MOV, 1'b0, DST_REG, SRC_IMM, R_AX, R_AX, 16'hFFFF, BASE_NONE, BASE_NONE,
          16'h0000, 8'h00, 3'd3}, 1'b1, '{16'd3, 1'b0, 1'b0, 16'hFFFF}},
      '{'{OP_MOV, 1'b0, DST_REG, SRC_IMM, R_CX, R_AX, 16'h8000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h00, 3'd3}, 1'b1, '{16'd6, 1'b0, 1'b0, 16'h8000}},
      '{'{OP_ADD, 1'b0, DST_REG, SRC_REG, R_AX, R_CX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h00, 3'd2}, 1'b1, '{16'd8, 1'b0, 1'b0, 16'h7FFF}},
      '{'{OP_SUB, 1'b0, DST_REG, SRC_IMM, R_DX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h00, 3'd4}, 1'b1, '{16'd12, 1'b1, 1'b0, 16'h0000}},
      '{'{OP_JE, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h7F, 3'd2}, 1'b1, '{16'd141, 1'b1, 1'b0, 16'h0000}},
      // word store at the top of the positive displacement range
      '{'{OP_MOV, 1'b1, DST_MEM, SRC_REG, R_AX, R_CX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h7FFF, 8'h00, 3'd6}, 1'b0, '0},
      // out-of-range base counts as no base
      '{'{OP_CMP, 1'b1, DST_MEM, SRC_IMM, R_AX, R_AX, 16'h8000, BASE_BAD, 4'(R_SI),
          16'h7FFF, 8'h00, 3'd5}, 1'b0, '0},
      '{'{OP_MOV, 1'b0, DST_MEM, SRC_IMM, R_AX, R_AX, 16'h12AB, BASE_NONE, BASE_NONE,
          16'h8000, 8'h00, 3'd4}, 1'b0, '0},
      '{'{OP_ADD, 1'b0, DST_REG, SRC_MEM, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h8000, 8'h00, 3'd3}, 1'b0, '0},
      '{'{OP_JS, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, 4'(R_BX), BASE_NONE,
          16'h0000, 8'h80, 3'd2}, 1'b0, '0},
      // jump without a jump destination never branches
      '{'{OP_JL, 1'b0, DST_REG, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h10, 3'd2}, 1'b0, '0},
      '{'{OP_JNS, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h05, 3'd2}, 1'b0, '0},
      '{'{OP_JNL, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h05, 3'd2}, 1'b0, '0},
      '{'{OP_JLE, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h10, 3'd2}, 1'b0, '0},
      '{'{OP_JG, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h10, 3'd2}, 1'b0, '0},
      '{'{OP_JNE, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'hFF, 3'd2}, 1'b0, '0},
      '{'{OP_SUB, 1'b0, DST_REG, SRC_IMM, R_CX, R_AX, 16'h0001, BASE_NONE, BASE_NONE,
          16'h0000, 8'h00, 3'd4}, 1'b0, '0},
      '{'{OP_JL, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h10, 3'd2}, 1'b0, '0},
      '{'{OP_JNL, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h0A, 3'd2}, 1'b0, '0},
      '{'{OP_JS, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h10, 3'd2}, 1'b0, '0},
      '{'{OP_JNS, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'hB0, 3'd2}, 1'b0, '0},
      '{'{OP_JE, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h10, 3'd2}, 1'b0, '0},
      '{'{OP_JG, 1'b0, DST_JMP, SRC_REG, R_AX, R_AX, 16'h0000, BASE_NONE, BASE_NONE,
          16'h0000, 8'h7F, 3'd2}, 1'b0, '0},
      // request code past the defined set, longest length field
      '{'{REQ_LAST, 1'b1, DST_REG, SRC_REG, R_AX, R_AX, 16'hFFFF, BASE_NONE, BASE_NONE,
          16'h0000, 8'h00, 3'd7}, 1'b0, '0},
      // alu into a jump destination with an unused source kind: flags still move
      '{'{OP_SUB, 1'b1, DST_JMP, KIND_UNUSED, R_DX, R_CX, 16'h5555, BASE_BAD, BASE_BAD,
          16'h0000, 8'h00, 3'd0}, 1'b0, '0},
      '{'{OP_MOV, 1'b0, KIND_UNUSED, SRC_IMM, R_AX, R_AX, 16'h1234, BASE_NONE, BASE_NONE,
          16'h0000, 8'h00, 3'd1}, 1'b0, '0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_instr(dir_tab[i].ins, dir_tab[i].typed, dir_tab[i].want);
    wait_drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 45 : 0;
      dst_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 19 : 0;
      repeat (RAND_PER_PHASE) send_instr(random_instr(), 1'b0, '0);
      // hold off until every owed result is back
      wait_drain();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d instructions issued (%0d from the directed table), %0d results compared",
             n_sent, N_DIR, n_checked);
    $display("%0d memory bytes written; sender/receiver stall mixes 19/45, 45/19, none",
             written_q.size());
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
